@@ rtl/bmpd_pkg.sv @@
// bmpd_pkg: constants, header field offsets, codes and shared types
// for the bmp24 stream decoder; no dependencies
package bmpd_pkg;

	localparam int DIM_BITS = 16;
	localparam int STRIDE_W = DIM_BITS + 2;
	localparam int PROD_W   = STRIDE_W + DIM_BITS;
	localparam int SUM_W    = ((PROD_W > 32) ? PROD_W : 32) + 1;

	localparam int HDR_LEN  = 54;
	localparam int POS_HW   = 6;

	localparam logic [15:0] BMP_SIGNATURE = 16'h4d42;
	localparam logic [31:0] DIB_MIN       = 32'd40;
	localparam logic [15:0] DEPTH_24      = 16'd24;
	localparam logic [15:0] ONE_PLANE     = 16'd1;
	localparam logic [32:0] FILE_HDR_LEN  = 33'd14;

	// byte offsets of the header fields that are checked
	localparam int OFS_SIG    = 0;
	localparam int OFS_OFFSET = 10;
	localparam int OFS_DIB    = 14;
	localparam int OFS_WIDTH  = 18;
	localparam int OFS_HEIGHT = 22;
	localparam int OFS_PLANES = 26;
	localparam int OFS_BPP    = 28;
	localparam int OFS_COMP   = 30;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam logic [3:0] ERR_NONE   = 4'd0;
	localparam logic [3:0] ERR_SIG    = 4'd1;
	localparam logic [3:0] ERR_DIB    = 4'd2;
	localparam logic [3:0] ERR_DIM    = 4'd3;
	localparam logic [3:0] ERR_PLANES = 4'd4;
	localparam logic [3:0] ERR_DEPTH  = 4'd5;
	localparam logic [3:0] ERR_COMP   = 4'd6;
	localparam logic [3:0] ERR_OFFSET = 4'd7;
	localparam logic [3:0] ERR_SHORT  = 4'd8;

	typedef struct packed {
		logic [3:0]          err;
		logic [DIM_BITS-1:0] width;
		logic [DIM_BITS-1:0] height;
		logic [31:0]         offset;
		logic [STRIDE_W-1:0] row_bytes;
		logic [STRIDE_W-1:0] stride;
	} hdr_res_t;

	function automatic logic in_field(logic [POS_HW-1:0] pos, int unsigned at,
		int unsigned len);
		return (pos >= POS_HW'(at)) && (pos < POS_HW'(at + len));
	endfunction

endpackage

@@ rtl/bmpd_hdr_check.sv @@
// bmpd_hdr_check: captures the checked header fields byte by byte and
// gives the check verdict, dimensions and row geometry; uses bmpd_pkg
module bmpd_hdr_check import bmpd_pkg::*; (
	input  logic              clk,
	input  logic              cap,
	input  logic [POS_HW-1:0] pos,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       file_size,
	output hdr_res_t          res
);

	logic [15:0] sig_q;
	logic [31:0] offs_q;
	logic [31:0] dib_q;
	logic [31:0] width_q;
	logic [31:0] height_q;
	logic [15:0] planes_q;
	logic [15:0] bpp_q;
	logic [31:0] comp_q;

	logic [STRIDE_W-1:0] row_bytes;
	logic [STRIDE_W-1:0] stride;
	logic [PROD_W-1:0]   prod_s1;
	logic [SUM_W-1:0]    sum_s2;

	// little-endian fields fill by shifting each new byte in at the top
	always_ff @(posedge clk) begin
		if (cap && in_field(pos, OFS_SIG, 2))    sig_q    <= {data_byte, sig_q[15:8]};
		if (cap && in_field(pos, OFS_OFFSET, 4)) offs_q   <= {data_byte, offs_q[31:8]};
		if (cap && in_field(pos, OFS_DIB, 4))    dib_q    <= {data_byte, dib_q[31:8]};
		if (cap && in_field(pos, OFS_WIDTH, 4))  width_q  <= {data_byte, width_q[31:8]};
		if (cap && in_field(pos, OFS_HEIGHT, 4)) height_q <= {data_byte, height_q[31:8]};
		if (cap && in_field(pos, OFS_PLANES, 2)) planes_q <= {data_byte, planes_q[15:8]};
		if (cap && in_field(pos, OFS_BPP, 2))    bpp_q    <= {data_byte, bpp_q[15:8]};
		if (cap && in_field(pos, OFS_COMP, 4))   comp_q   <= {data_byte, comp_q[31:8]};
	end

	assign row_bytes = STRIDE_W'({width_q[DIM_BITS-1:0], 1'b0})
		+ STRIDE_W'(width_q[DIM_BITS-1:0]);
	assign stride = (row_bytes + STRIDE_W'(3)) & ~STRIDE_W'(3);

	// pixel area end runs ahead every cycle; fields are complete long before
	// the final header byte arrives
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(stride) * PROD_W'(height_q[DIM_BITS-1:0]);
		sum_s2  <= SUM_W'(offs_q) + SUM_W'(prod_s1);
	end

	always_comb begin
		priority if (sig_q != BMP_SIGNATURE) begin
			res.err = ERR_SIG;
		end else if (dib_q < DIB_MIN) begin
			res.err = ERR_DIB;
		end else if ((width_q == '0) || (height_q == '0)
			|| (width_q[31:DIM_BITS] != '0) || (height_q[31:DIM_BITS] != '0)) begin
			res.err = ERR_DIM;
		end else if (planes_q != ONE_PLANE) begin
			res.err = ERR_PLANES;
		end else if (bpp_q != DEPTH_24) begin
			res.err = ERR_DEPTH;
		end else if (comp_q != '0) begin
			res.err = ERR_COMP;
		end else if ({1'b0, offs_q} < ({1'b0, dib_q} + FILE_HDR_LEN)) begin
			res.err = ERR_OFFSET;
		end else if (sum_s2 > SUM_W'(file_size)) begin
			res.err = ERR_SHORT;
		end else begin
			res.err = ERR_NONE;
		end
		res.width     = width_q[DIM_BITS-1:0];
		res.height    = height_q[DIM_BITS-1:0];
		res.offset    = offs_q;
		res.row_bytes = row_bytes;
		res.stride    = stride;
	end

endmodule

@@ rtl/bmp24_stream_decoder.sv @@
// bmp24_stream_decoder: top level, byte stream in, header/pixel/error items out
// depends on bmpd_pkg and bmpd_hdr_check
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata: data_byte; tuser: cmd
// m_*       out  m_tvalid/m_tready  tdata: colours, dims, error; tuser: kind; tlast: last
// cfg_*     in   cfg_wen            cfg_wdata: file_size
//
// one byte accepted per cycle unless the skid entry is full; each result is registered
// the final header byte is checked combinationally against fields captured earlier
// reset clears phase, counters, kept geometry and file_size
// an output register plus one skid entry let input continue while output stalls;
// input is held off only while the skid entry is full
module bmp24_stream_decoder import bmpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
	                               // [39:24] image_width, [55:40] image_height,
	                               // [59:56] error_code, rest zero
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast,   // last
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_SKIP   = 2'd1;
	localparam logic [1:0] PH_PIXELS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] width;
		logic [15:0] height;
		logic [3:0]  err;
		logic        last;
	} res_t;

	logic [1:0]          phase_q;
	logic [31:0]         pos_q;
	logic [DIM_BITS-1:0] row_q;
	logic [STRIDE_W-1:0] bir_q;
	logic [1:0]          slot_q;
	logic [7:0]          blue_q;
	logic [7:0]          green_q;
	logic [DIM_BITS-1:0] kept_h_q;
	logic [31:0]         kept_offs_q;
	logic [STRIDE_W-1:0] row_bytes_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [31:0]         file_size_q;

	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;

	logic                acc;
	logic                data_acc;
	logic                hdr_end;
	logic                in_row;
	logic                pix_last;
	logic [STRIDE_W-1:0] bir_inc;
	logic                row_end;
	logic [31:0]         pos_inc;
	hdr_res_t            hres;
	res_t                res;
	logic                res_v;

	assign s_tready = !skid_v_q;
	assign acc      = s_tvalid && s_tready;
	assign data_acc = acc && !s_tuser[0];

	bmpd_hdr_check u_hdr_check (
		.clk       (clk),
		.cap       (data_acc && (phase_q == PH_HEADER)),
		.pos       (pos_q[POS_HW-1:0]),
		.data_byte (s_tdata),
		.file_size (file_size_q),
		.res       (hres)
	);

	assign pos_inc  = pos_q + 32'd1;
	assign hdr_end  = (phase_q == PH_HEADER) && (pos_q[POS_HW-1:0] == POS_HW'(HDR_LEN - 1));
	assign in_row   = bir_q < row_bytes_q;
	assign bir_inc  = bir_q + STRIDE_W'(1);
	assign row_end  = bir_inc >= stride_q;
	assign pix_last = ((row_q + DIM_BITS'(1)) == kept_h_q) && (bir_inc == row_bytes_q);

	always_comb begin
		res   = '0;
		res_v = 1'b0;
		if (data_acc) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_end) begin
						res_v = 1'b1;
						if (hres.err != ERR_NONE) begin
							res.kind = KIND_ERROR;
							res.err  = hres.err;
						end else begin
							res.kind   = KIND_HEADER;
							res.width  = 16'(hres.width);
							res.height = 16'(hres.height);
						end
					end
				end
				PH_PIXELS: begin
					if (in_row && (slot_q == 2'd2)) begin
						res_v     = 1'b1;
						res.kind  = KIND_PIXEL;
						res.red   = s_tdata;
						res.green = green_q;
						res.blue  = blue_q;
						res.last  = pix_last;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg_wen) begin
			file_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			pos_q       <= '0;
			row_q       <= '0;
			bir_q       <= '0;
			slot_q      <= '0;
			kept_h_q    <= '0;
			kept_offs_q <= '0;
			row_bytes_q <= '0;
			stride_q    <= '0;
		end else if (acc && s_tuser[0]) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			row_q   <= '0;
			bir_q   <= '0;
			slot_q  <= '0;
		end else if (data_acc) begin
			unique case (phase_q)
				PH_HEADER: begin
					pos_q <= pos_inc;
					if (hdr_end) begin
						if (hres.err != ERR_NONE) begin
							phase_q <= PH_DONE;
						end else begin
							kept_h_q    <= hres.height;
							kept_offs_q <= hres.offset;
							row_bytes_q <= hres.row_bytes;
							stride_q    <= hres.stride;
							row_q       <= '0;
							bir_q       <= '0;
							slot_q      <= '0;
							phase_q     <= (32'(HDR_LEN) >= hres.offset) ? PH_PIXELS : PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					pos_q <= pos_inc;
					if (pos_inc >= kept_offs_q) phase_q <= PH_PIXELS;
				end
				PH_PIXELS: begin
					if (in_row && (slot_q == 2'd2) && pix_last) begin
						phase_q <= PH_DONE;
					end else if (row_end) begin
						bir_q  <= '0;
						slot_q <= '0;
						row_q  <= row_q + DIM_BITS'(1);
					end else begin
						bir_q  <= bir_inc;
						// slot wraps every triple; padding bytes only cycle it until row end
						slot_q <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (data_acc && (phase_q == PH_PIXELS) && in_row) begin
			if (slot_q == 2'd0) blue_q <= s_tdata;
			if (slot_q == 2'd1) green_q <= s_tdata;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && !m_tready) begin
			if (res_v) skid_v_q <= 1'b1;
		end else if (skid_v_q) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end else begin
			out_v_q <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_v_q && !m_tready) begin
			if (res_v) skid_q <= res;
		end else if (skid_v_q) begin
			out_q <= skid_q;
		end else begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'b0, out_q.err, out_q.height, out_q.width,
		out_q.blue, out_q.green, out_q.red};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

`ifndef SYNTH
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry full while output register empty");

	a_last_ends_image: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v && res.last) |=> (phase_q == PH_DONE))
		else $error("final pixel did not end the image");

	a_header_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (pos_q < 32'(HDR_LEN)))
		else $error("header position ran past the header");

	a_row_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PIXELS) |-> (bir_q < stride_q))
		else $error("byte in row beyond stride");
`endif

endmodule

@@ test/bmpd_checker.sv @@
// bmpd_checker: watches the byte, result and config channels of the bmp24 stream decoder,
// predicts every decoded item and compares it with what the block delivers
// depends on bmpd_pkg
module bmpd_checker import bmpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] cmd
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
	                               // [39:24] image_width, [55:40] image_height,
	                               // [59:56] error_code
	input  logic [1:0]  m_tuser,   // [1:0] kind
	input  logic        m_tlast,
	input  logic        cfg_wen,
	input  logic [31:0] cfg_wdata,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {DEC_HEADER, DEC_SKIP, DEC_PIXELS, DEC_DONE} dec_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] width;
		logic [15:0] height;
		logic [3:0]  err;
		logic        is_last;
	} bmp_item_t;

	dec_phase_t  phase = DEC_HEADER;
	logic [31:0] file_len = '0;
	logic [31:0] byte_pos = '0;
	logic [7:0]  hdr_bytes [HDR_LEN];
	logic [31:0] row_cnt = '0;
	logic [31:0] row_byte = '0;
	logic [15:0] held_bg = '0;
	logic [31:0] img_w = '0;
	logic [31:0] img_h = '0;
	logic [31:0] pix_offset = '0;
	bmp_item_t   decoded_q [$];
	int          n_fail = 0;

	function automatic logic [15:0] hdr16(int at);
		return {hdr_bytes[at+1], hdr_bytes[at]};
	endfunction

	function automatic logic [31:0] hdr32(int at);
		return {hdr16(at + 2), hdr16(at)};
	endfunction

	// checks run in order of their codes, the first failure wins
	function automatic logic [3:0] header_verdict();
		logic [63:0] lim;
		logic [63:0] offs;
		logic [63:0] dib;
		logic [63:0] w;
		logic [63:0] h;
		logic [63:0] stride;
		lim    = 64'd1 << DIM_BITS;
		offs   = {32'd0, hdr32(OFS_OFFSET)};
		dib    = {32'd0, hdr32(OFS_DIB)};
		w      = {32'd0, hdr32(OFS_WIDTH)};
		h      = {32'd0, hdr32(OFS_HEIGHT)};
		if (hdr16(OFS_SIG) != BMP_SIGNATURE) return ERR_SIG;
		if (dib < 64'(DIB_MIN)) return ERR_DIB;
		if (w == 0 || h == 0 || w >= lim || h >= lim) return ERR_DIM;
		if (hdr16(OFS_PLANES) != ONE_PLANE) return ERR_PLANES;
		if (hdr16(OFS_BPP) != DEPTH_24) return ERR_DEPTH;
		if (hdr32(OFS_COMP) != 32'd0) return ERR_COMP;
		if (offs < 64'(FILE_HDR_LEN) + dib) return ERR_OFFSET;
		stride = (w * 64'd3 + 64'd3) & ~64'd3;
		if (offs + stride * h > {32'd0, file_len}) return ERR_SHORT;
		return ERR_NONE;
	endfunction

	function automatic void decode_byte(logic cmd, logic [7:0] b);
		bmp_item_t   res;
		logic [3:0]  verdict;
		logic [31:0] row_bytes;
		logic [31:0] stride;
		res = '0;
		if (cmd) begin
			phase    = DEC_HEADER;
			byte_pos = '0;
			row_cnt  = '0;
			row_byte = '0;
			held_bg  = '0;
			return;
		end
		case (phase)
			DEC_HEADER: begin
				if (byte_pos < HDR_LEN) hdr_bytes[byte_pos] = b;
				byte_pos++;
				if (byte_pos >= HDR_LEN) begin
					verdict = header_verdict();
					if (verdict != ERR_NONE) begin
						phase    = DEC_DONE;
						res.kind = KIND_ERROR;
						res.err  = verdict;
					end else begin
						img_w      = hdr32(OFS_WIDTH);
						img_h      = hdr32(OFS_HEIGHT);
						pix_offset = hdr32(OFS_OFFSET);
						row_cnt    = '0;
						row_byte   = '0;
						held_bg    = '0;
						phase      = (byte_pos >= pix_offset) ? DEC_PIXELS : DEC_SKIP;
						res.kind   = KIND_HEADER;
						res.width  = img_w[15:0];
						res.height = img_h[15:0];
					end
					decoded_q.push_back(res);
				end
			end
			DEC_SKIP: begin
				byte_pos++;
				if (byte_pos >= pix_offset) phase = DEC_PIXELS;
			end
			DEC_PIXELS: begin
				row_bytes = img_w * 3;
				stride    = (row_bytes + 3) & ~32'd3;
				byte_pos++;
				if (row_byte < row_bytes) begin
					case (row_byte % 3)
						0: held_bg[7:0]  = b;
						1: held_bg[15:8] = b;
						default: begin
							res.kind  = KIND_PIXEL;
							res.red   = b;
							res.green = held_bg[15:8];
							res.blue  = held_bg[7:0];
							if (row_cnt + 1 == img_h && row_byte + 1 == row_bytes) begin
								res.is_last = 1'b1;
								phase       = DEC_DONE;
								decoded_q.push_back(res);
								return;
							end
							decoded_q.push_back(res);
						end
					endcase
				end
				row_byte++;
				if (row_byte >= stride) begin
					row_byte = '0;
					row_cnt++;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void note_fail(string msg);
		n_fail++;
		if (n_fail <= 10) $display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bmp_item_t got;
		bmp_item_t want;
		if (!arst_n) begin
			phase      = DEC_HEADER;
			file_len   = '0;
			byte_pos   = '0;
			row_cnt    = '0;
			row_byte   = '0;
			held_bg    = '0;
			img_w      = '0;
			img_h      = '0;
			pix_offset = '0;
			decoded_q.delete();
		end else begin
			if (cfg_wen) file_len = cfg_wdata;
			// a result never shows in the same cycle as its byte, so compare before predicting
			if (m_tvalid && m_tready) begin
				got.kind    = m_tuser;
				got.red     = m_tdata[7:0];
				got.green   = m_tdata[15:8];
				got.blue    = m_tdata[23:16];
				got.width   = m_tdata[39:24];
				got.height  = m_tdata[55:40];
				got.err     = m_tdata[59:56];
				got.is_last = m_tlast;
				if (decoded_q.size() == 0) begin
					note_fail($sformatf({"unexpected item kind=%0d rgb=%02h%02h%02h",
						" w=%0d h=%0d err=%0d last=%0b"},
						got.kind, got.red, got.green, got.blue, got.width, got.height,
						got.err, got.is_last));
				end else begin
					want = decoded_q.pop_front();
					if (got.kind != want.kind || got.red != want.red ||
						got.green != want.green || got.blue != want.blue ||
						got.width != want.width || got.height != want.height ||
						got.err != want.err || got.is_last != want.is_last) begin
						note_fail($sformatf({"mismatch: expected kind=%0d",
							" rgb=%02h%02h%02h w=%0d h=%0d err=%0d last=%0b,",
							" got kind=%0d rgb=%02h%02h%02h w=%0d h=%0d",
							" err=%0d last=%0b"},
							want.kind, want.red, want.green, want.blue, want.width,
							want.height, want.err, want.is_last, got.kind, got.red,
							got.green, got.blue, got.width, got.height, got.err,
							got.is_last));
					end
				end
			end
			if (s_tvalid && s_tready) decode_byte(s_tuser[0], s_tdata);
		end
		fail_count  = n_fail;
		outstanding = decoded_q.size();
	end

endmodule

@@ test/tb_bmp24_stream_decoder.sv @@
// tb_bmp24_stream_decoder: streams directed and random bmp files into the decoder
// with random gaps and output stalls; depends on bmpd_pkg, bmp24_stream_decoder, bmpd_checker
module tb_bmp24_stream_decoder;
	import bmpd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 240;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_wen;
	logic [31:0] cfg_wdata;
	int          fail_count;
	int          outstanding;

	logic [7:0]  img [$];
	bit          vld_on = 0;
	bit          idle_on = 1;
	bit          stall_on = 1;
	int          cyc = 0;

	bmp24_stream_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	bmpd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// result side back-pressure
	initial begin
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!m_tready) begin
				m_tready <= 1'b1;
				hold = $urandom_range(0, 24);
			end else if (stall_on && $urandom_range(0, 99) < 20) begin
				m_tready <= 1'b0;
				hold = stall_len() - 1;
			end
		end
	end

	task automatic send_item(logic cmd, logic [7:0] b);
		int gap;
		s_tuser <= cmd;
		s_tdata <= b;
		if (!vld_on) begin
			s_tvalid <= 1'b1;
			vld_on = 1;
		end
		do @(posedge clk); while (!s_tready);
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			vld_on = 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic restart();
		send_item(1'b1, 8'($urandom));
	endtask

	task automatic play(int n);
		for (int i = 0; i < n && i < img.size(); i++) send_item(1'b0, img[i]);
	endtask

	task automatic set_le(int at, logic [31:0] v, int n);
		for (int i = 0; i < n; i++) img[at+i] = v[8*i +: 8];
	endtask

	// well-formed header around the given geometry, unchecked bytes random
	task automatic begin_header(logic [31:0] w, logic [31:0] h, logic [31:0] dib,
		logic [31:0] offs);
		img.delete();
		repeat (HDR_LEN) img.push_back(8'($urandom));
		set_le(OFS_SIG, BMP_SIGNATURE, 2);
		set_le(OFS_OFFSET, offs, 4);
		set_le(OFS_DIB, dib, 4);
		set_le(OFS_WIDTH, w, 4);
		set_le(OFS_HEIGHT, h, 4);
		set_le(OFS_PLANES, ONE_PLANE, 2);
		set_le(OFS_BPP, DEPTH_24, 2);
		set_le(OFS_COMP, 32'd0, 4);
	endtask

	task automatic add_pixels(int w, int h, int offs, int extra);
		int stride;
		int skip;
		stride = ((w * 3 + 3) / 4) * 4;
		skip   = (offs > HDR_LEN) ? offs - HDR_LEN : 0;
		repeat (skip + h * stride + extra) img.push_back(8'($urandom));
	endtask

	task automatic play_good(int w, int h, int dib, int offs, int extra);
		begin_header(w, h, dib, offs);
		add_pixels(w, h, offs, extra);
		play(img.size());
		restart();
	endtask

	// bytes after an error must be ignored
	task automatic play_bad();
		repeat (2) img.push_back(8'($urandom));
		play(img.size());
		restart();
	endtask

	task automatic drain();
		if (vld_on) begin
			s_tvalid <= 1'b0;
			vld_on = 0;
		end
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_file_size(logic [31:0] v);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	task automatic random_file(output int useful);
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] dib;
		logic [31:0] offs;
		logic [31:0] v;
		int          mode;
		int          cut;
		int          tail;
		w    = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
		h    = $urandom_range(1, 6);
		dib  = ($urandom_range(0, 99) < 70) ? 40 : $urandom_range(41, 100);
		offs = 14 + dib + (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10));
		idle_on  = ($urandom_range(0, 99) >= 25);
		stall_on = ($urandom_range(0, 99) >= 25);
		begin_header(w, h, dib, offs);
		mode = $urandom_range(0, 99);
		if (mode < 14) begin
			case ($urandom_range(0, 7))
				0: img[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
				1: set_le(OFS_DIB, $urandom_range(0, 39), 4);
				2: set_le(OFS_WIDTH, ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h1_0000), 4);
				3: set_le(OFS_HEIGHT, ($urandom_range(0, 1) == 0) ? 32'd0 : ($urandom | 32'h1_0000), 4);
				4: begin
					v = $urandom_range(0, 65535);
					if (v == 1) v = 0;
					set_le(OFS_PLANES, v, 2);
				end
				5: begin
					v = $urandom_range(0, 65535);
					if (v == 24) v = 25;
					set_le(OFS_BPP, v, 2);
				end
				6: set_le(OFS_COMP, $urandom | 32'd1, 4);
				default: set_le(OFS_OFFSET, $urandom_range(0, 13 + dib), 4);
			endcase
			tail = $urandom_range(0, 3);
			repeat (tail) img.push_back(8'($urandom));
			play(img.size());
			useful = HDR_LEN;
		end else if (mode < 22) begin
			// file cut short, then restarted
			add_pixels(w, h, offs, 0);
			cut = $urandom_range(1, img.size() - 1);
			play(cut);
			useful = cut;
		end else if (mode < 26) begin
			img.delete();
			cut = $urandom_range(1, 80);
			repeat (cut) img.push_back(8'($urandom));
			play(cut);
			useful = (cut < HDR_LEN) ? cut : HDR_LEN;
		end else begin
			add_pixels(w, h, offs, 0);
			useful = img.size();
			tail = $urandom_range(0, 4);
			repeat (tail) img.push_back(8'($urandom));
			play(img.size());
		end
		restart();
		useful++;
	endtask

	initial begin
		logic [31:0] size_sel [4];
		int          total;
		int          chunk;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_file_size(32'hffff_ffff);

		// zero skip with trailing bytes, then padding, then a long dib
		play_good(1, 1, 40, 54, 3);
		play_good(2, 3, 40, 60, 0);
		play_good(5, 2, 124, 140, 2);
		begin_header(1, 1, 40, 54);
		img[0] = 8'h4c;
		play_bad();
		begin_header(1, 1, 39, 54);
		play_bad();
		// dib fault takes precedence over dimension and depth faults
		begin_header(0, 1, 39, 54);
		set_le(OFS_BPP, 32'd32, 2);
		play_bad();
		begin_header(0, 1, 40, 54);
		play_bad();
		begin_header(1, 32'hffff_fff0, 40, 54);
		play_bad();
		begin_header(65536, 1, 40, 54);
		play_bad();
		begin_header(1, 1, 40, 54);
		set_le(OFS_PLANES, 32'd2, 2);
		play_bad();
		begin_header(1, 1, 40, 54);
		set_le(OFS_BPP, 32'd32, 2);
		play_bad();
		begin_header(1, 1, 40, 54);
		set_le(OFS_COMP, 32'd1, 4);
		play_bad();
		begin_header(1, 1, 40, 53);
		play_bad();
		// sum beyond 32 bits must not wrap
		begin_header(65535, 65535, 40, 54);
		play_bad();
		// largest width accepted, a few pixels, restart mid image
		begin_header(65535, 1, 40, 54);
		repeat (9) img.push_back(8'($urandom));
		play(img.size());
		restart();
		// restart in the middle of a header
		begin_header(3, 2, 40, 54);
		play(20);
		restart();
		add_pixels(3, 2, 54, 0);
		play(img.size());
		restart();

		drain();
		set_file_size(32'd0);
		begin_header(1, 1, 40, 54);
		play_bad();
		drain();
		set_file_size(32'd69);
		begin_header(2, 2, 40, 54);
		play_bad();
		drain();
		set_file_size(32'd70);
		play_good(2, 2, 40, 54, 1);

		size_sel[0] = 32'hffff_ffff;
		size_sel[1] = $urandom_range(60, 400);
		size_sel[2] = 32'h8000_0000;
		size_sel[3] = $urandom;
		total = 0;
		for (int p = 0; p < 4; p++) begin
			drain();
			set_file_size(size_sel[p]);
			while (total < (RANDOM_ITEMS * (p + 1)) / 4) begin
				random_file(chunk);
				total += chunk;
			end
		end

		drain();
		@(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
